// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker in ntrig_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion, active through reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion, switched off while the active-low reset is asserted.
`define ASSERT_CLK_RSTN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

// ===== sv/ntrig_pkg.sv =====
// ----------------------------------------------------------------------------
// ntrig_pkg
// Types, constants and helpers for the note and CV pulse trigger.
// ----------------------------------------------------------------------------
`default_nettype none

package ntrig_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int CV_BITS      = 10;
    localparam int TICKS_PER_MS = 1000;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PRE_W  = $clog2(TICKS_PER_MS + 1);

    // Fixed field widths
    localparam int PULSE_W  = 6;
    localparam int SETTLE_W = 9;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int STEP_W   = 4;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 9;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CFG_AW-1:0] {
        REG_PULSE_MS  = 2'd0,
        REG_SETTLE_US = 2'd1,
        REG_NOTE_BASE = 2'd2
    } reg_idx_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_NOTE = 1'b1
    } func_t;

    // Input payload, gate_level in bit 0
    typedef struct packed {
        logic              is_note_on;
        logic [VEL_W-1:0]  note_velocity;
        logic [NOTE_W-1:0] note_number;
        logic [CV_BITS-1:0] cv_sample;
        logic              gate_level;
    } in_data_t;

    localparam int IN_DATA_W = $bits(in_data_t);

    // Result payload, drive in the low bits
    typedef struct packed {
        logic [VEL_W-1:0]        recent_velocity;
        logic                    note_seen;
        logic [NOTE_W-1:0]       recent_note;
        logic                    gate_low;
        logic [STEP_W-1:0]       cv_step;
        logic [CV_BITS-1:0]      held_cv;
        logic [NUM_CHANNELS-1:0] drive;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_ms;
        logic [SETTLE_W-1:0] settle_delay_us;
        logic [NOTE_W-1:0]   note_base;
    } cfg_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] ch;
    } fire_t;

    typedef struct packed {
        logic [CV_BITS-1:0] held_cv;
        logic [STEP_W-1:0]  cv_step;
        logic               gate_low;
        logic [NOTE_W-1:0]  recent_note;
        logic               note_seen;
        logic [VEL_W-1:0]   recent_velocity;
    } ctrl_view_t;

    // cv * NUM_CHANNELS / 2^CV_BITS
    function automatic logic [CH_W-1:0] cv_step_of(input logic [CV_BITS-1:0] cv);
        logic [CV_BITS+CH_W-1:0] prod;
        prod = {{CH_W{1'b0}}, cv} * (CV_BITS + CH_W)'(NUM_CHANNELS);
        return prod[CV_BITS+CH_W-1:CV_BITS];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ntrig_timers.sv =====
// ----------------------------------------------------------------------------
// ntrig_timers
// Microsecond prescaler and the per-channel millisecond pulse counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ntrig_timers
    import ntrig_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    tick_adv,
    input  wire logic                    item_adv,
    input  wire fire_t                   fire,
    input  wire logic [PULSE_W-1:0]      pulse_ms,
    output      logic [NUM_CHANNELS-1:0] drive_next
);

    localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(TICKS_PER_MS - 1);

    logic [PRE_W-1:0]   prescale_reg, prescale_next;
    logic [PULSE_W-1:0] ms_left_reg  [NUM_CHANNELS];
    logic [PULSE_W-1:0] ms_left_next [NUM_CHANNELS];
    logic               ms_tick;

    assign ms_tick = tick_adv && (prescale_reg == PRE_LAST);

    always_comb begin
        if (!tick_adv) begin
            prescale_next = prescale_reg;
        end else if (ms_tick) begin
            prescale_next = '0;
        end else begin
            prescale_next = prescale_reg + PRE_W'(1);
        end
    end

    // Countdown first, then a fire reloads the channel
    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (fire.en && (fire.ch == CH_W'(i))) begin
                ms_left_next[i] = pulse_ms;
            end else if (ms_tick && (ms_left_reg[i] != '0)) begin
                ms_left_next[i] = ms_left_reg[i] - PULSE_W'(1);
            end else begin
                ms_left_next[i] = ms_left_reg[i];
            end
            drive_next[i] = (ms_left_next[i] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                ms_left_reg[i] <= '0;
            end
        end else if (item_adv) begin
            prescale_reg <= prescale_next;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                ms_left_reg[i] <= ms_left_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ntrig_ctrl.sv =====
// ----------------------------------------------------------------------------
// ntrig_ctrl
// Gate edge and settle wait, CV latch, and MIDI note decode.
// ----------------------------------------------------------------------------
`default_nettype none

module ntrig_ctrl
    import ntrig_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       item_adv,
    input  wire func_t      func,
    input  wire in_data_t   item,
    input  wire cfg_t       cfg,
    output      fire_t      fire,
    output      ctrl_view_t view_next
);

    logic [SETTLE_W-1:0] settle_left_reg, settle_left_next, settle_dec;
    logic                settling_reg, settling_next;
    logic                prev_gate_reg, prev_gate_next;
    logic [CV_BITS-1:0]  cv_latch_reg, cv_latch_next;
    logic [NOTE_W-1:0]   note_reg, note_next;
    logic                seen_reg, seen_next;
    logic [VEL_W-1:0]    vel_reg, vel_next;
    logic                note_on;
    logic [NOTE_W:0]     note_off;
    logic                note_hit;
    logic                latch_now;

    assign settle_dec = (settle_left_reg != '0) ? settle_left_reg - SETTLE_W'(1)
                                                : settle_left_reg;
    assign note_on  = item.is_note_on && (item.note_velocity != '0);
    assign note_off = {1'b0, item.note_number} - {1'b0, cfg.note_base};
    assign note_hit = note_on && !note_off[NOTE_W]
                      && (note_off < (NOTE_W + 1)'(NUM_CHANNELS));

    always_comb begin
        settle_left_next = settle_left_reg;
        settling_next    = settling_reg;
        prev_gate_next   = prev_gate_reg;
        cv_latch_next    = cv_latch_reg;
        note_next        = note_reg;
        seen_next        = seen_reg;
        vel_next         = vel_reg;
        latch_now        = 1'b0;
        fire             = '0;

        unique case (func)
            FUNC_TICK: begin
                if (settling_reg) begin
                    // gate is ignored until the wait runs out
                    settle_left_next = settle_dec;
                    if (settle_dec == '0) begin
                        settling_next = 1'b0;
                        latch_now     = 1'b1;
                    end
                end else begin
                    if (prev_gate_reg && !item.gate_level) begin
                        settle_left_next = cfg.settle_delay_us;
                        if (cfg.settle_delay_us == '0) begin
                            latch_now = 1'b1;
                        end else begin
                            settling_next = 1'b1;
                        end
                    end
                    prev_gate_next = item.gate_level;
                end
                if (latch_now) begin
                    cv_latch_next = item.cv_sample;
                    fire.en       = 1'b1;
                    fire.ch       = cv_step_of(item.cv_sample);
                end
            end
            FUNC_NOTE: begin
                note_next = item.note_number;
                vel_next  = note_on ? item.note_velocity : '0;
                seen_next = 1'b1;
                fire.en   = note_hit;
                fire.ch   = note_off[CH_W-1:0];
            end
            default: begin
            end
        endcase

        view_next.held_cv         = cv_latch_next;
        view_next.cv_step         = STEP_W'(cv_step_of(cv_latch_next));
        view_next.gate_low        = !prev_gate_next;
        view_next.recent_note     = note_next;
        view_next.note_seen       = seen_next;
        view_next.recent_velocity = vel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_left_reg <= '0;
            settling_reg    <= 1'b0;
            prev_gate_reg   <= 1'b1;
            cv_latch_reg    <= '0;
            note_reg        <= '0;
            seen_reg        <= 1'b0;
            vel_reg         <= '0;
        end else if (item_adv) begin
            settle_left_reg <= settle_left_next;
            settling_reg    <= settling_next;
            prev_gate_reg   <= prev_gate_next;
            cv_latch_reg    <= cv_latch_next;
            note_reg        <= note_next;
            seen_reg        <= seen_next;
            vel_reg         <= vel_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/note_and_cv_pulse_trigger.sv =====
// ----------------------------------------------------------------------------
// note_and_cv_pulse_trigger
// Twelve-channel solenoid one-shot driver fired by MIDI notes and CV/gate.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  handshake
//  s_*       in   tick (gate, CV) or note event            tvalid/tready
//  m_*       out  drive mask, held CV, step, note status   tvalid/tready
//  cfg_*     in   pulse_ms, settle_delay_us, note_base     write enable only
//
//  One item per cycle sustained while m_tready is high; an item taken on s_*
//  goes through the input register, then the result register, to m_*. All
//  channel timers update in parallel. Reset is synchronous and active low.
//  A stall on m_tready holds both stages; s_tready drops only when both are
//  full and m_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module note_and_cv_pulse_trigger
    import ntrig_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // [0] gate_level, [10:1] cv_sample, [17:11] note_number,
    // [24:18] note_velocity, [25] is_note_on, [31:26] ignored
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] func
    input  wire logic                 s_tuser,

    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [11:0] drive, [21:12] held_cv, [25:22] cv_step, [26] gate_low,
    // [33:27] recent_note, [34] note_seen, [41:35] recent_velocity, [47:42] zero
    output      logic [M_TDATA_W-1:0] m_tdata,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_DW-1:0]    cfg_wdata
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    func_t      in_func_reg;
    in_data_t   in_data_reg;
    logic       m_valid_reg;
    result_t    result_reg;

    logic       out_ready;
    logic       item_adv;
    logic       s_fire;
    fire_t      fire;
    ctrl_view_t view_next;
    logic [NUM_CHANNELS-1:0] drive_next;

    assign out_ready = !m_valid_reg || m_tready;
    assign item_adv  = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_ms        <= PULSE_W'(30);
            cfg_reg.settle_delay_us <= SETTLE_W'(200);
            cfg_reg.note_base       <= NOTE_W'(36);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PULSE_MS:  cfg_reg.pulse_ms        <= cfg_wdata[PULSE_W-1:0];
                REG_SETTLE_US: cfg_reg.settle_delay_us <= cfg_wdata[SETTLE_W-1:0];
                REG_NOTE_BASE: cfg_reg.note_base       <= cfg_wdata[NOTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_func_reg <= func_t'(s_tuser);
            in_data_reg <= in_data_t'(s_tdata[IN_DATA_W-1:0]);
        end
    end

    ntrig_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_adv  (item_adv),
        .func      (in_func_reg),
        .item      (in_data_reg),
        .cfg       (cfg_reg),
        .fire      (fire),
        .view_next (view_next)
    );

    ntrig_timers u_timers (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_adv   (item_adv && (in_func_reg == FUNC_TICK)),
        .item_adv   (item_adv),
        .fire       (fire),
        .pulse_ms   (cfg_reg.pulse_ms),
        .drive_next (drive_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_adv) begin
            result_reg.drive           <= drive_next;
            result_reg.held_cv         <= view_next.held_cv;
            result_reg.cv_step         <= view_next.cv_step;
            result_reg.gate_low        <= view_next.gate_low;
            result_reg.recent_note     <= view_next.recent_note;
            result_reg.note_seen       <= view_next.note_seen;
            result_reg.recent_velocity <= view_next.recent_velocity;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, result_reg};

endmodule

`default_nettype wire

// ===== sv/ntrig_checker.sv =====
// ----------------------------------------------------------------------------
// ntrig_checker
// Port-level checks on the pulse trigger, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ntrig_checker
    import ntrig_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic              in_xfer;
    logic              out_stall;
    logic [STEP_W-1:0] res_step;
    logic [VEL_W-1:0]  res_vel;
    logic              res_seen;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign res_step  = m_tdata[25:22];
    assign res_vel   = m_tdata[41:35];
    assign res_seen  = m_tdata[34];

    // no result right after reset
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // a held result keeps its payload
    `ASSERT_CLK_RSTN(a_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable(m_tdata),
        "stalled result changed")

    // an accepted transaction is followed by m_tvalid on the output side
    `ASSERT_CLK_RSTN(a_in_to_out, aclk, aresetn, in_xfer |-> ##2 m_tvalid,
        "accepted transaction produced no result")

    // quantized step never leaves the channel range
    `ASSERT_CLK_RSTN(a_step_range, aclk, aresetn,
        m_tvalid |-> res_step < STEP_W'(NUM_CHANNELS), "cv_step out of range")

    // a nonzero velocity can only come from a seen note
    `ASSERT_CLK_RSTN(a_vel_seen, aclk, aresetn, m_tvalid && (res_vel != '0) |-> res_seen,
        "velocity without note")

endmodule

bind note_and_cv_pulse_trigger ntrig_checker u_ntrig_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/pulse_trigger_checker.sv =====
// ----------------------------------------------------------------------------
// pulse_trigger_checker
// Watches the stream and config ports of the pulse trigger, keeps its own
// copy of the channel timers, settle logic and note status, and compares
// each output transaction with the oldest predicted result.
// ----------------------------------------------------------------------------
module pulse_trigger_checker
    import ntrig_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_DW-1:0]    cfg_wdata,
    output int                        mismatches,
    output int                        outstanding,
    output int                        compared,
    output int                        cv_latches,
    output int                        pulse_expiries
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy
    logic [PULSE_W-1:0]  pulse_len;
    logic [SETTLE_W-1:0] settle_len;
    logic [NOTE_W-1:0]   base_note;

    // block state copy
    logic [PULSE_W-1:0]  ms_left [NUM_CHANNELS];
    int unsigned         us_count;
    logic [SETTLE_W-1:0] settle_count;
    logic                settle_active;
    logic                last_gate;
    logic [CV_BITS-1:0]  cv_held;
    logic [NOTE_W-1:0]   held_note;
    logic                any_note;
    logic [VEL_W-1:0]    held_vel;

    result_t predicted_results [$];
    int err_count;
    int cmp_count;
    int latch_count;
    int expiry_count;

    initial begin
        err_count    = 0;
        cmp_count    = 0;
        latch_count  = 0;
        expiry_count = 0;
    end

    function automatic logic [STEP_W-1:0] step_for(input logic [CV_BITS-1:0] cv);
        int unsigned prod;
        prod = int'(cv) * NUM_CHANNELS;
        return STEP_W'(prod >> CV_BITS);
    endfunction

    task automatic clear_model();
        pulse_len     = PULSE_W'(30);
        settle_len    = SETTLE_W'(200);
        base_note     = NOTE_W'(36);
        for (int i = 0; i < NUM_CHANNELS; i++) ms_left[i] = '0;
        us_count      = 0;
        settle_count  = '0;
        settle_active = 1'b0;
        last_gate     = 1'b1;
        cv_held       = '0;
        held_note     = '0;
        any_note      = 1'b0;
        held_vel      = '0;
        predicted_results.delete();
    endtask

    task automatic fire_channel(input int ch);
        if (ch < NUM_CHANNELS) ms_left[ch] = pulse_len;
    endtask

    task automatic latch_sample(input logic [CV_BITS-1:0] cv);
        cv_held = cv;
        latch_count++;
        fire_channel(int'(step_for(cv)));
    endtask

    task automatic advance_trigger(input func_t f, input in_data_t d);
        result_t                 r;
        logic [NUM_CHANNELS-1:0] mask;
        logic                    is_on;
        int                      offset;
        if (f == FUNC_TICK) begin
            // ms boundary first, so a pulse fired this tick keeps its full length
            us_count++;
            if (us_count >= TICKS_PER_MS) begin
                us_count = 0;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    if (ms_left[i] != 0) begin
                        ms_left[i] = ms_left[i] - 1'b1;
                        if (ms_left[i] == 0) expiry_count++;
                    end
                end
            end
            if (settle_active) begin
                // gate not watched while settling
                if (settle_count != 0) settle_count = settle_count - 1'b1;
                if (settle_count == 0) begin
                    settle_active = 1'b0;
                    latch_sample(d.cv_sample);
                end
            end else begin
                if (last_gate && !d.gate_level) begin
                    settle_count = settle_len;
                    if (settle_len == 0) latch_sample(d.cv_sample);
                    else settle_active = 1'b1;
                end
                last_gate = d.gate_level;
            end
        end else begin
            is_on     = d.is_note_on && (d.note_velocity != 0);
            held_note = d.note_number;
            held_vel  = is_on ? d.note_velocity : '0;
            any_note  = 1'b1;
            offset    = int'(d.note_number) - int'(base_note);
            if (is_on && offset >= 0 && offset < NUM_CHANNELS) fire_channel(offset);
        end

        for (int i = 0; i < NUM_CHANNELS; i++) mask[i] = (ms_left[i] != 0);
        r                 = '0;
        r.drive           = mask;
        r.held_cv         = cv_held;
        r.cv_step         = step_for(cv_held);
        r.gate_low        = !last_gate;
        r.recent_note     = held_note;
        r.note_seen       = any_note;
        r.recent_velocity = held_vel;
        predicted_results.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, predicted 0x%0h",
                                      cmp_count, name, got, want));
    endtask

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PULSE_MS:  pulse_len  = cfg_wdata[PULSE_W-1:0];
                    REG_SETTLE_US: settle_len = cfg_wdata[SETTLE_W-1:0];
                    REG_NOTE_BASE: base_note  = cfg_wdata[NOTE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (predicted_results.size() == 0) begin
                    report_mismatch($sformatf("output transaction 0x%0h with no prediction",
                                              got));
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("drive", got.drive, want.drive);
                    compare_field("held_cv", got.held_cv, want.held_cv);
                    compare_field("cv_step", got.cv_step, want.cv_step);
                    compare_field("gate_low", got.gate_low, want.gate_low);
                    compare_field("recent_note", got.recent_note, want.recent_note);
                    compare_field("note_seen", got.note_seen, want.note_seen);
                    compare_field("recent_velocity", got.recent_velocity,
                                  want.recent_velocity);
                    cmp_count++;
                end
            end
            if (s_tvalid && s_tready)
                advance_trigger(func_t'(s_tuser), s_tdata[IN_DATA_W-1:0]);
        end
        mismatches     <= err_count;
        outstanding    <= predicted_results.size();
        compared       <= cmp_count;
        cv_latches     <= latch_count;
        pulse_expiries <= expiry_count;
    end

endmodule

// ===== tb/sv/note_and_cv_pulse_trigger_test.sv =====
// ----------------------------------------------------------------------------
// note_and_cv_pulse_trigger_test
// Stimulus and verdict for the pulse trigger: directed notes and gate/CV
// ticks, then random phases under several register settings and idling
// patterns, including a long output stall. Checking lives in the checker.
// ----------------------------------------------------------------------------
module note_and_cv_pulse_trigger_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ntrig_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_GAP        = 40;
    localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    int mismatch_count;
    int outstanding;
    int compared;
    int cv_latches;
    int pulse_expiries;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int idle_cycles    = 0;

    int ticks_sent     = 0;
    int notes_sent     = 0;
    int settings_used  = 0;

    logic [NOTE_W-1:0] cur_base = NOTE_W'(36);
    logic              gate_now = 1'b1;
    int                gate_run = 0;

    note_and_cv_pulse_trigger u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pulse_trigger_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatch_count),
        .outstanding    (outstanding),
        .compared       (compared),
        .cv_latches     (cv_latches),
        .pulse_expiries (pulse_expiries)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin : receiver
        int hold_left;
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("note_and_cv_pulse_trigger regression: fail");
            $finish;
        end
    end

    task automatic offer_event(input func_t f, input in_data_t d);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= S_TDATA_W'(d);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (f == FUNC_TICK) ticks_sent++;
        else notes_sent++;
    endtask

    // unused fields carry random bits
    task automatic send_tick(input logic gate, input logic [CV_BITS-1:0] cv);
        in_data_t d;
        d            = IN_DATA_W'($urandom);
        d.gate_level = gate;
        d.cv_sample  = cv;
        offer_event(FUNC_TICK, d);
    endtask

    task automatic send_note(input logic [NOTE_W-1:0] num, input logic [VEL_W-1:0] vel,
                             input logic on);
        in_data_t d;
        d               = IN_DATA_W'($urandom);
        d.note_number   = num;
        d.note_velocity = vel;
        d.is_note_on    = on;
        offer_event(FUNC_NOTE, d);
    endtask

    task automatic drain_block();
        @(negedge aclk) s_tvalid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_DW-1:0] pulse,
                                  input logic [CFG_DW-1:0] settle,
                                  input logic [CFG_DW-1:0] base);
        drain_block();
        write_reg(REG_PULSE_MS, pulse);
        write_reg(REG_SETTLE_US, settle);
        write_reg(REG_NOTE_BASE, base);
        cur_base = base[NOTE_W-1:0];
        settings_used++;
    endtask

    // gate runs have random lengths up to max_run; some are short glitches
    task automatic run_random(input int count, input int tick_pct, input int max_run);
        logic [CV_BITS-1:0] cv;
        logic [NOTE_W-1:0]  num;
        logic [VEL_W-1:0]   vel;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < tick_pct) begin
                if (gate_run == 0) begin
                    gate_now = ~gate_now;
                    gate_run = ($urandom_range(99) < 80) ? $urandom_range(1, max_run)
                                                        : $urandom_range(1, 3);
                end
                gate_run--;
                case ($urandom_range(9))
                    0:       cv = '0;
                    1:       cv = '1;
                    default: cv = CV_BITS'($urandom);
                endcase
                send_tick(gate_now, cv);
            end else begin
                num = ($urandom_range(99) < 75) ? cur_base + NOTE_W'($urandom_range(11))
                                                 : NOTE_W'($urandom);
                vel = ($urandom_range(99) < 80) ? VEL_W'($urandom_range(1, 127)) : '0;
                send_note(num, vel, $urandom_range(99) < 85);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // directed: window edges, note off, zero velocity, settle of one tick
        apply_settings(20, 1, 0);
        send_note(0, 127, 1'b1);
        send_note(11, 1, 1'b1);
        send_note(12, 127, 1'b1);
        send_note(5, 100, 1'b0);
        send_note(6, 0, 1'b1);
        send_note(127, 127, 1'b1);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd0);
        send_note(3, 64, 1'b1);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd512);
        send_tick(1'b1, 10'd0);

        // zero settle, zero pulse, top of the note range, bad register index
        apply_settings(0, 0, 116);
        write_reg(REG_UNUSED, '1);
        send_tick(1'b0, 10'd85);
        send_note(127, 127, 1'b1);
        send_note(116, 1, 1'b1);
        send_note(115, 127, 1'b1);
        send_tick(1'b1, 10'd1023);
        send_tick(1'b0, 10'd1023);
        send_tick(1'b0, 10'd0);
        send_tick(1'b1, 10'd683);

        // no idling; long output hold-off fills the pipe
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_settings(30, 3, 36);
        @(posedge aclk) hold_req = 1'b1;
        run_random(110, 70, 10);

        send_idle_pct  = 72;
        recv_stall_pct = 0;
        apply_settings(50, 50, 120);
        run_random(110, 75, 70);

        // tick-heavy: long settle waits under dense gate activity
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        apply_settings(1, 500, 0);
        run_random(500, 93, 30);

        // write data wider than the registers
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        apply_settings(9'h114, 9'h000, 9'h174);
        run_random(110, 60, 6);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_settings(2, 9'h1FF, 127);
        run_random(50, 70, 8);

        drain_block();
        $display("covered %0d transactions (%0d ticks, %0d note events) over %0d settings",
                 ticks_sent + notes_sent, ticks_sent, notes_sent, settings_used);
        $display("%0d results compared, %0d cv latches, %0d pulse expiries, %0d mismatches",
                 compared, cv_latches, pulse_expiries, mismatch_count);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("note_and_cv_pulse_trigger regression: pass");
        end else begin
            $display("note_and_cv_pulse_trigger regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ntrig_pkg.sv
sv/ntrig_timers.sv
sv/ntrig_ctrl.sv
sv/note_and_cv_pulse_trigger.sv
sv/ntrig_checker.sv
tb/sv/pulse_trigger_checker.sv
tb/sv/note_and_cv_pulse_trigger_test.sv
